// ===== rtl/core/h2r_pkg.sv =====
`timescale 1ns / 1ps

package h2r_pkg;

  // hue wrap: bias by a multiple of 360 so the value is non-negative,
  // then divide by 360 through a reciprocal (estimate low by at most one)
  localparam int unsigned HueBias       = 33120;  // 92 * 360
  localparam int unsigned HueRecip      = 46603;  // floor(2^24 / 360)
  localparam int unsigned HueRecipShift = 24;
  localparam int unsigned HueWrap       = 360;

  // common denominator of all fractions, unit value 1.0
  localparam int unsigned Denom       = 1200000;
  localparam int unsigned HalfDenom   = 600000;
  localparam int unsigned FullScale   = 255;
  localparam int unsigned LevelRecip  = 916259;   // floor(2^40 / Denom)
  localparam int unsigned LevelShift  = 40;

  typedef struct packed {
    logic signed [15:0] hue_degrees;
    logic signed [7:0]  saturation_percent;
    logic signed [7:0]  lightness_percent;
  } hsl_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
  } rgb_t;

  // wrapped hue, chroma numerator over 10000, clamped lightness
  typedef struct packed {
    logic [8:0]  hue;
    logic [13:0] chroma_num;
    logic [6:0]  light;
  } prep_t;

  // 255 * v + D/2 for each channel, to be divided by D
  typedef struct packed {
    logic [28:0] red_num;
    logic [28:0] green_num;
    logic [28:0] blue_num;
  } mix_t;

  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  function automatic logic [6:0] clamp_pct(input logic signed [7:0] v);
    logic [6:0] r;
    if (v < 8'sd0) begin
      r = 7'd0;
    end else if (v > 8'sd100) begin
      r = 7'd100;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// HSL to RGB converter, six register stages.
// An accepted word passes through stages A to F in order before output valid.
// Throughput: one word per cycle; the whole pipe holds while the output word waits.
// Reset: rst_ni (async, active low) clears the stage valid bits only;
// data registers are not reset and the block has no other state.

module hsl_to_rgb_converter import h2r_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  hsl_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rgb_t out_data_o
);

  localparam int unsigned Stages = 6;

  // One shared advance enable: the pipe moves whenever the output slot is
  // free or is being taken this cycle, and then a new word enters each cycle.
  logic              adv;
  logic [Stages-1:0] valid_d, valid_q;

  assign adv        = !valid_q[Stages-1] || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    valid_d = valid_q;
    if (adv) begin
      valid_d = {valid_q[Stages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // stages A-B: hue wrap, clamps, chroma numerator
  prep_t prep;
  h2r_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (adv),
    .hsl_i  (in_data_i),
    .prep_o (prep)
  );

  // stages C-D: sector pick, X / C / m, rounding numerators
  mix_t mix;
  h2r_mix u_mix (
    .clk_i  (clk_i),
    .en_i   (adv),
    .prep_i (prep),
    .mix_o  (mix)
  );

  // stages E-F: divide by the common denominator, one unit per channel
  rgb_t rgb;
  h2r_quant u_quant_r (
    .clk_i   (clk_i),
    .en_i    (adv),
    .num_i   (mix.red_num),
    .level_o (rgb.red_level)
  );

  h2r_quant u_quant_g (
    .clk_i   (clk_i),
    .en_i    (adv),
    .num_i   (mix.green_num),
    .level_o (rgb.green_level)
  );

  h2r_quant u_quant_b (
    .clk_i   (clk_i),
    .en_i    (adv),
    .num_i   (mix.blue_num),
    .level_o (rgb.blue_level)
  );

  assign out_valid_o = valid_q[Stages-1];
  assign out_data_o  = rgb;

  // back-pressure only comes from an output word left waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("pipe stalled with empty output slot");

  // an accepted word shows up in the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted word lost at entry");

  // a stall freezes every stage valid bit
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(valid_q))
    else $error("stage valid changed during stall");

endmodule

// ===== rtl/core/h2r_prep.sv =====
`timescale 1ns / 1ps

module h2r_prep import h2r_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  hsl_t  hsl_i,
  output prep_t prep_o
);

  // stage A: bias, reciprocal multiply, clamp
  logic [16:0] biased;
  logic [16:0] ubias_d, ubias_q;
  logic [32:0] prod;
  logic [7:0]  quot_d, quot_q;
  logic [6:0]  sat_d, sat_q, lit_d, lit_q;

  assign biased  = {hsl_i.hue_degrees[15], hsl_i.hue_degrees} + 17'(HueBias);
  assign ubias_d = biased;
  assign prod    = 33'(ubias_d) * 33'(HueRecip);
  assign quot_d  = prod[HueRecipShift +: 8];
  assign sat_d   = clamp_pct(hsl_i.saturation_percent);
  assign lit_d   = clamp_pct(hsl_i.lightness_percent);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ubias_q <= ubias_d;
      quot_q  <= quot_d;
      sat_q   <= sat_d;
      lit_q   <= lit_d;
    end
  end

  // stage B: remainder with one correction, chroma numerator
  logic [16:0] qmul;
  logic [16:0] rem;
  logic [8:0]  hue;
  logic [7:0]  two_l;
  logic [6:0]  ldev;
  logic [6:0]  span;
  logic [13:0] cnum;
  prep_t       prep_d, prep_q;

  assign qmul = 17'(quot_q) * 17'(HueWrap);
  assign rem  = ubias_q - qmul;
  assign hue  = (rem >= 17'(HueWrap)) ? 9'(rem - 17'(HueWrap)) : rem[8:0];

  assign two_l = {lit_q, 1'b0};
  assign ldev  = (two_l >= 8'd100) ? 7'(two_l - 8'd100) : 7'(8'd100 - two_l);
  assign span  = 7'd100 - ldev;
  assign cnum  = 14'(span) * 14'(sat_q);

  always_comb begin
    prep_d            = '0;
    prep_d.hue        = hue;
    prep_d.chroma_num = cnum;
    prep_d.light      = lit_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

// ===== rtl/core/h2r_mix.sv =====
`timescale 1ns / 1ps

module h2r_mix import h2r_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  prep_t prep_i,
  output mix_t  mix_o
);

  // stage C: sector, X, C and m, all over Denom
  logic [6:0]  hmod;
  logic [5:0]  hdist;
  logic [5:0]  xfac;
  logic [19:0] xnum;
  logic [20:0] chr_d, chr_q, xc_d, xc_q, ofs_d, ofs_q;
  logic [20:0] lterm, cterm;
  sector_e     sec_d, sec_q;

  assign hmod = (prep_i.hue >= 9'd240) ? 7'(prep_i.hue - 9'd240) :
                (prep_i.hue >= 9'd120) ? 7'(prep_i.hue - 9'd120) : prep_i.hue[6:0];
  assign hdist = (hmod >= 7'd60) ? 6'(hmod - 7'd60) : 6'(7'd60 - hmod);
  assign xfac  = 6'd60 - hdist;
  assign xnum  = 20'(prep_i.chroma_num) * 20'(xfac);
  assign xc_d  = {xnum, 1'b0};
  assign chr_d = 21'(prep_i.chroma_num) * 21'd120;
  assign lterm = 21'(prep_i.light) * 21'd12000;
  assign cterm = 21'(prep_i.chroma_num) * 21'd60;
  assign ofs_d = lterm - cterm;   // L - C/2, never negative

  always_comb begin
    if (prep_i.hue < 9'd60) begin
      sec_d = SecRedYel;
    end else if (prep_i.hue < 9'd120) begin
      sec_d = SecYelGrn;
    end else if (prep_i.hue < 9'd180) begin
      sec_d = SecGrnCyn;
    end else if (prep_i.hue < 9'd240) begin
      sec_d = SecCynBlu;
    end else if (prep_i.hue < 9'd300) begin
      sec_d = SecBluMag;
    end else begin
      sec_d = SecMagRed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      chr_q <= chr_d;
      xc_q  <= xc_d;
      ofs_q <= ofs_d;
      sec_q <= sec_d;
    end
  end

  // stage D: route to channels, add m, form rounding numerator
  logic [20:0] rsel, gsel, bsel;
  logic [20:0] rv, gv, bv;
  mix_t        mix_d, mix_q;

  always_comb begin
    case (sec_q)
      SecRedYel: begin rsel = chr_q; gsel = xc_q;  bsel = '0;    end
      SecYelGrn: begin rsel = xc_q;  gsel = chr_q; bsel = '0;    end
      SecGrnCyn: begin rsel = '0;    gsel = chr_q; bsel = xc_q;  end
      SecCynBlu: begin rsel = '0;    gsel = xc_q;  bsel = chr_q; end
      SecBluMag: begin rsel = xc_q;  gsel = '0;    bsel = chr_q; end
      default:   begin rsel = chr_q; gsel = '0;    bsel = xc_q;  end
    endcase
  end

  assign rv = rsel + ofs_q;
  assign gv = gsel + ofs_q;
  assign bv = bsel + ofs_q;

  always_comb begin
    mix_d           = '0;
    mix_d.red_num   = 29'(rv) * 29'(FullScale) + 29'(HalfDenom);
    mix_d.green_num = 29'(gv) * 29'(FullScale) + 29'(HalfDenom);
    mix_d.blue_num  = 29'(bv) * 29'(FullScale) + 29'(HalfDenom);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

// ===== rtl/core/h2r_quant.sv =====
`timescale 1ns / 1ps

module h2r_quant import h2r_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [28:0] num_i,
  output logic [7:0]  level_o
);

  // stage E: quotient estimate by reciprocal, low by at most one
  logic [48:0] prod;
  logic [7:0]  qest_d, qest_q;
  logic [28:0] num_q;

  assign prod   = 49'(num_i) * 49'(LevelRecip);
  assign qest_d = prod[LevelShift +: 8];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qest_q <= qest_d;
      num_q  <= num_i;
    end
  end

  // stage F: one correction step, saturate
  logic [28:0] qmul;
  logic [28:0] rem;
  logic [8:0]  qfix;
  logic [7:0]  level_d, level_q;

  assign qmul    = 29'(qest_q) * 29'(Denom);
  assign rem     = num_q - qmul;
  assign qfix    = 9'(qest_q) + ((rem >= 29'(Denom)) ? 9'd1 : 9'd0);
  assign level_d = (qfix > 9'(FullScale)) ? 8'(FullScale) : qfix[7:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule
